/* sv/dtc_pkg.sv */
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared types and codes of the decision tree classifier: item and result
// layouts, node table entry, memory request and response groups.
// ----------------------------------------------------------------------------
package dtc_pkg;

  // Field widths fixed by the item format
  localparam int IDX_W     = 8;
  localparam int FIDX_W    = 4;
  localparam int VAL_W     = 16;
  localparam int CLS_W     = 8;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // Operation codes
  localparam logic [1:0] OP_NODE_WR  = 2'd0;
  localparam logic [1:0] OP_FEAT_WR  = 2'd1;
  localparam logic [1:0] OP_CLASSIFY = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_LIMIT   = 2'd2;

  // Register index (paddr bit 2 selects the 32-bit word)
  localparam logic REG_ROOT = 1'b0;

  typedef struct packed {
    logic [1:0]              operation;
    logic [IDX_W-1:0]        node_index;
    logic                    node_is_leaf;
    logic [FIDX_W-1:0]       node_feature;
    logic signed [VAL_W-1:0] node_threshold;
    logic [IDX_W-1:0]        node_left;
    logic [IDX_W-1:0]        node_right;
    logic [CLS_W-1:0]        node_class;
    logic [FIDX_W-1:0]       feature_index;
    logic signed [VAL_W-1:0] feature_value;
  } dtc_in_t;

  typedef struct packed {
    logic [CLS_W-1:0] predicted_class;
    logic [1:0]       status;
  } dtc_out_t;

  // One node table entry (45 bits)
  typedef struct packed {
    logic                    leaf;
    logic [FIDX_W-1:0]       feat;
    logic signed [VAL_W-1:0] thr;
    logic [IDX_W-1:0]        left;
    logic [IDX_W-1:0]        right;
    logic [CLS_W-1:0]        cls;
  } node_entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_index;
    node_entry_t      wr_entry;
    logic             rd_en;
    logic [IDX_W-1:0] rd_index;
  } node_req_t;

  typedef struct packed {
    logic        ready;  // clearing pass done
    logic        hit;    // last read was in range and written
    node_entry_t entry;
  } node_rsp_t;

  typedef struct packed {
    logic                    wr_en;
    logic [FIDX_W-1:0]       wr_index;
    logic signed [VAL_W-1:0] wr_value;
    logic                    rd_en;
    logic [FIDX_W-1:0]       rd_index;
  } feat_req_t;

endpackage

/* sv/dtc_node_mem.sv */
// ----------------------------------------------------------------------------
// dtc_node_mem
// Node table: one synchronous memory holding entry plus valid bit, with a
// clearing pass after reset and range checks on both ports.
// ----------------------------------------------------------------------------
module dtc_node_mem #(
  parameter int NODE_COUNT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dtc_pkg::node_req_t  req_i,
  output dtc_pkg::node_rsp_t  rsp_o
);

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int EW = $bits(dtc_pkg::node_entry_t);
  localparam int DW = EW + 1;

  logic [DW-1:0] mem_q [NODE_COUNT];

  logic          clearing_q;
  logic [AW-1:0] clr_addr_q;
  logic          wr_in_range;
  logic          rd_in_range;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [DW-1:0] mem_wr_data;
  logic [DW-1:0] rd_word_q;
  logic          rd_in_range_q;

  // Range checks and address conversion
  assign wr_in_range = int'(req_i.wr_index) < NODE_COUNT;
  assign rd_in_range = int'(req_i.rd_index) < NODE_COUNT;
  assign wr_addr     = AW'(req_i.wr_index);
  assign rd_addr     = AW'(req_i.rd_index);

  // Write port: clearing pass has priority
  always_comb begin
    if (clearing_q) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_addr_q;
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = req_i.wr_en && wr_in_range;
      mem_wr_addr = wr_addr;
      mem_wr_data = {1'b1, req_i.wr_entry};
    end
  end

  // Clearing pass, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      if (clr_addr_q == AW'(NODE_COUNT - 1)) begin
        clearing_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // Memory write
  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      mem_q[mem_wr_addr] <= mem_wr_data;
    end
  end

  // Memory read, registered data held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_in_range_q <= rd_in_range;
      rd_word_q     <= mem_q[rd_addr];
    end
  end

  assign rsp_o.ready = !clearing_q;
  assign rsp_o.hit   = rd_in_range_q && rd_word_q[DW-1];
  assign rsp_o.entry = dtc_pkg::node_entry_t'(rd_word_q[EW-1:0]);

endmodule

/* sv/dtc_feat_mem.sv */
// ----------------------------------------------------------------------------
// dtc_feat_mem
// Sample feature store: synchronous memory, one write and one read port,
// out-of-range feature indices read as zero.
// ----------------------------------------------------------------------------
module dtc_feat_mem #(
  parameter int FEATURE_COUNT = 16
) (
  input  logic                      clk_i,
  input  dtc_pkg::feat_req_t        req_i,
  output logic signed [dtc_pkg::VAL_W-1:0] value_o
);

  localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;

  logic [dtc_pkg::VAL_W-1:0] mem_q [FEATURE_COUNT];

  logic                      wr_in_range;
  logic                      rd_in_range;
  logic [FW-1:0]             wr_addr;
  logic [FW-1:0]             rd_addr;
  logic [dtc_pkg::VAL_W-1:0] rd_data_q;
  logic                      rd_in_range_q;

  assign wr_in_range = int'(req_i.wr_index) < FEATURE_COUNT;
  assign rd_in_range = int'(req_i.rd_index) < FEATURE_COUNT;
  assign wr_addr     = FW'(req_i.wr_index);
  assign rd_addr     = FW'(req_i.rd_index);

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && wr_in_range) begin
      mem_q[wr_addr] <= req_i.wr_value;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_in_range_q <= rd_in_range;
      rd_data_q     <= mem_q[rd_addr];
    end
  end

  assign value_o = rd_in_range_q ? $signed(rd_data_q) : '0;

endmodule

/* sv/dtc_walk.sv */
// ----------------------------------------------------------------------------
// dtc_walk
// Item decode and tree walk sequencer: issues table writes, then walks the
// tree (node read, then a feature read for an inner node) and registers the result.
// ----------------------------------------------------------------------------
module dtc_walk #(
  parameter int MAX_DEPTH = 15
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  dtc_pkg::dtc_in_t                item_i,
  input  logic [dtc_pkg::IDX_W-1:0]       root_i,
  output logic                            busy_o,
  output logic                            result_valid_o,
  output dtc_pkg::dtc_out_t               result_o,
  output dtc_pkg::node_req_t              node_req_o,
  input  dtc_pkg::node_rsp_t              node_rsp_i,
  output dtc_pkg::feat_req_t              feat_req_o,
  input  logic signed [dtc_pkg::VAL_W-1:0] feat_value_i
);

  localparam int VW = $clog2(MAX_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_NODE,
    S_FEAT
  } state_e;

  state_e                   state_q;
  logic [VW-1:0]            visits_q;
  logic                     result_valid_q;
  dtc_pkg::dtc_out_t        result_q;

  logic                     accept;
  logic                     last_visit;
  logic                     go_left;
  logic [dtc_pkg::IDX_W-1:0] child;

  assign accept     = start_i && (state_q == S_IDLE) && node_rsp_i.ready;
  assign last_visit = (visits_q == VW'(MAX_DEPTH));

  // Branch decision: at or below threshold goes left
  assign go_left = feat_value_i <= node_rsp_i.entry.thr;
  assign child   = go_left ? node_rsp_i.entry.left : node_rsp_i.entry.right;

  // Node table requests
  always_comb begin
    node_req_o.wr_en             = accept && (item_i.operation == dtc_pkg::OP_NODE_WR);
    node_req_o.wr_index          = item_i.node_index;
    node_req_o.wr_entry.leaf     = item_i.node_is_leaf;
    node_req_o.wr_entry.feat     = item_i.node_feature;
    node_req_o.wr_entry.thr      = item_i.node_threshold;
    node_req_o.wr_entry.left     = item_i.node_left;
    node_req_o.wr_entry.right    = item_i.node_right;
    node_req_o.wr_entry.cls      = item_i.node_class;
    node_req_o.rd_en             = (accept && (item_i.operation == dtc_pkg::OP_CLASSIFY))
                                 || ((state_q == S_FEAT) && !last_visit);
    node_req_o.rd_index          = (state_q == S_FEAT) ? child : root_i;
  end

  // Feature store requests
  always_comb begin
    feat_req_o.wr_en    = accept && (item_i.operation == dtc_pkg::OP_FEAT_WR);
    feat_req_o.wr_index = item_i.feature_index;
    feat_req_o.wr_value = item_i.feature_value;
    feat_req_o.rd_en    = (state_q == S_NODE) && node_rsp_i.hit && !node_rsp_i.entry.leaf;
    feat_req_o.rd_index = node_rsp_i.entry.feat;
  end

  // Walk sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      visits_q       <= '0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
    end else begin
      result_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept && (item_i.operation == dtc_pkg::OP_CLASSIFY)) begin
            visits_q <= '0;
            state_q  <= S_NODE;
          end
        end
        S_NODE: begin
          if (!node_rsp_i.hit) begin
            result_valid_q           <= 1'b1;
            result_q.predicted_class <= '0;
            result_q.status          <= dtc_pkg::ST_MISSING;
            state_q                  <= S_IDLE;
          end else if (node_rsp_i.entry.leaf) begin
            result_valid_q           <= 1'b1;
            result_q.predicted_class <= node_rsp_i.entry.cls;
            result_q.status          <= dtc_pkg::ST_OK;
            state_q                  <= S_IDLE;
          end else begin
            state_q <= S_FEAT;
          end
        end
        S_FEAT: begin
          if (last_visit) begin
            result_valid_q           <= 1'b1;
            result_q.predicted_class <= '0;
            result_q.status          <= dtc_pkg::ST_LIMIT;
            state_q                  <= S_IDLE;
          end else begin
            visits_q <= visits_q + 1'b1;
            state_q  <= S_NODE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o         = (state_q != S_IDLE) || !node_rsp_i.ready;
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

/* sv/decision_tree_classifier.sv */
// ----------------------------------------------------------------------------
// decision_tree_classifier
// Binary decision tree inference over a stored node table and sample.
// ----------------------------------------------------------------------------
// Items are taken when start is high and busy is low. Node writes, feature
// writes and the unused operation code give no result. A classify visits
// at most MAX_DEPTH+1 nodes and reports the step limit when the last of them
// is not a leaf; each inner node costs a node table read followed by a
// dependent sample feature read, both synchronous memories, and a leaf only
// the node table read. The result shows on result_o for exactly one cycle
// with result_valid_o high; there is no backpressure, so the receiver must
// take it then. After reset the node table is swept clear of all NODE_COUNT
// entries, during which busy stays high; the root register can be written
// over the APB port at any time the block idles.
// ----------------------------------------------------------------------------
module decision_tree_classifier #(
  parameter int NODE_COUNT    = 256,
  parameter int FEATURE_COUNT = 16,
  parameter int MAX_DEPTH     = 15
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  dtc_pkg::dtc_in_t                item_i,
  output logic                            result_valid_o,
  output dtc_pkg::dtc_out_t               result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dtc_pkg::PADDR_W-1:0]     paddr,
  input  logic [dtc_pkg::PDATA_W-1:0]     pwdata,
  output logic [dtc_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  logic [dtc_pkg::IDX_W-1:0] root_q;
  logic                      cfg_wr;
  dtc_pkg::node_req_t        node_req;
  dtc_pkg::node_rsp_t        node_rsp;
  dtc_pkg::feat_req_t        feat_req;
  logic signed [dtc_pkg::VAL_W-1:0] feat_value;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_wr && (paddr[2] == dtc_pkg::REG_ROOT)) begin
      root_q <= pwdata[dtc_pkg::IDX_W-1:0];
    end
  end

  assign prdata = (paddr[2] == dtc_pkg::REG_ROOT)
                ? {{(dtc_pkg::PDATA_W - dtc_pkg::IDX_W){1'b0}}, root_q}
                : '0;

  // Walk sequencer
  dtc_walk #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .item_i         (item_i),
    .root_i         (root_q),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .node_req_o     (node_req),
    .node_rsp_i     (node_rsp),
    .feat_req_o     (feat_req),
    .feat_value_i   (feat_value)
  );

  // Node table
  dtc_node_mem #(
    .NODE_COUNT (NODE_COUNT)
  ) u_node_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (node_req),
    .rsp_o  (node_rsp)
  );

  // Sample features
  dtc_feat_mem #(
    .FEATURE_COUNT (FEATURE_COUNT)
  ) u_feat_mem (
    .clk_i   (clk_i),
    .req_i   (feat_req),
    .value_o (feat_value)
  );

  // Results are never back to back: a classify reaches its result through a registered walk state
  a_result_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  // A failed walk reports class zero
  a_fail_class_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.status != dtc_pkg::ST_OK))
      |-> (result_o.predicted_class == '0))
    else $error("nonzero class on failed walk");

  // An accepted classify holds the block busy
  a_classify_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.operation == dtc_pkg::OP_CLASSIFY)) |=> busy)
    else $error("classify accepted without going busy");

  // A result marks the end of its walk
  a_result_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result while walk still running");

endmodule
